/* design/oat_pkg.sv */
package oat_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int ADDR_BITS_DEF     = 48;
  localparam int SIZE_BITS_DEF     = 32;

  localparam int ADDRESS_W = 48;
  localparam int ASIZE_W   = 32;
  localparam int COUNT_W   = 9;
  localparam int BYTES_W   = 48;

  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NULL = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [ADDRESS_W-1:0] address;
    logic [ASIZE_W-1:0]   alloc_size;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   entry_count;
    logic [ASIZE_W-1:0]   freed_size;
    logic [BYTES_W-1:0]   usage_now;
    logic [BYTES_W-1:0]   usage_peak;
    logic [BYTES_W-1:0]   bytes_total;
  } out_item_t;

endpackage

/* design/oat_mem.sv */
module oat_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/oat_ctrl.sv */
module oat_ctrl
  import oat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int AW            = ADDR_BITS_DEF,
  parameter int SW            = SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  in_item_t                         in_data,
  output logic                             out_valid,
  output out_item_t                        out_data,
  output logic                             wr_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
  output logic [AW-1:0]                    wr_addr,
  output logic [SW-1:0]                    wr_size,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rd_idx,
  input  logic [AW-1:0]                    rd_addr,
  input  logic [SW-1:0]                    rd_size
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_LAST = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [BYTES_W-1:0] cur_r, cur_nxt;
  logic [BYTES_W-1:0] peak_r, peak_nxt;
  logic [BYTES_W-1:0] total_r, total_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [IW-1:0]      chk_r, chk_nxt;
  logic [IW-1:0]      hit_r, hit_nxt;
  logic [SW-1:0]      freed_r, freed_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               accept;
  logic [AW-1:0]      in_addr;
  logic [SW-1:0]      in_size;
  logic               full;
  logic [IW-1:0]      last_idx;
  logic               match;
  logic [BYTES_W:0]   total_sum;
  logic [BYTES_W:0]   cur_sum;
  logic [BYTES_W-1:0] cur_add;
  logic [BYTES_W-1:0] cur_sub;
  status_t            status;
  logic [SW-1:0]      freed;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_addr  = AW'(in_data.address);
  assign in_size  = SW'(in_data.alloc_size);
  assign full     = (count_r == CW'(TABLE_ENTRIES));
  assign last_idx = IW'(count_r - CW'(1));
  assign match    = (rd_addr == addr_r);

  assign total_sum = {1'b0, total_r} + (BYTES_W+1)'(in_size);
  assign cur_sum   = {1'b0, cur_r} + (BYTES_W+1)'(in_size);
  assign cur_add   = cur_sum[BYTES_W] ? BYTES_MAX : cur_sum[BYTES_W-1:0];
  assign cur_sub   = (cur_r >= BYTES_W'(freed_r)) ? cur_r - BYTES_W'(freed_r) : '0;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    peak_nxt      = peak_r;
    total_nxt     = total_r;
    addr_nxt      = addr_r;
    chk_nxt       = chk_r;
    hit_nxt       = hit_r;
    freed_nxt     = freed_r;
    out_valid_nxt = 1'b0;
    status        = ST_DONE;
    freed         = '0;
    wr_en         = 1'b0;
    wr_idx        = hit_r;
    wr_addr       = in_addr;
    wr_size       = in_size;
    rd_idx        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_addr == '0) begin
            status        = ST_NULL;
            out_valid_nxt = 1'b1;
          end else if (in_data.kind == KIND_ALLOC) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_idx    = IW'(count_r);
              count_nxt = count_r + CW'(1);
              total_nxt = total_sum[BYTES_W] ? BYTES_MAX : total_sum[BYTES_W-1:0];
              cur_nxt   = cur_add;
              peak_nxt  = (cur_add > peak_r) ? cur_add : peak_r;
            end
          end else if (count_r == '0) begin
            status        = ST_MISS;
            out_valid_nxt = 1'b1;
          end else begin
            addr_nxt  = in_addr;
            chk_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt   = chk_r;
          freed_nxt = rd_size;
          rd_idx    = last_idx;
          state_nxt = S_LAST;
        end else if (CW'(chk_r) == count_r - CW'(1)) begin
          status        = ST_MISS;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          chk_nxt = chk_r + IW'(1);
          rd_idx  = chk_r + IW'(1);
        end
      end
      S_LAST: begin
        wr_en         = 1'b1;
        wr_idx        = hit_r;
        wr_addr       = rd_addr;
        wr_size       = rd_size;
        count_nxt     = count_r - CW'(1);
        cur_nxt       = cur_sub;
        freed         = freed_r;
        status        = ST_DONE;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.status      = status;
    out_nxt.entry_count = COUNT_W'(count_nxt);
    out_nxt.freed_size  = ASIZE_W'(freed);
    out_nxt.usage_now   = cur_nxt;
    out_nxt.usage_peak  = peak_nxt;
    out_nxt.bytes_total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      peak_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      peak_r      <= peak_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    chk_r   <= chk_nxt;
    hit_r   <= hit_nxt;
    freed_r <= freed_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/outstanding_allocation_tracker.sv */
// Allocations, null addresses, full-table drops and releases on an empty table
// give their result in the next cycle after start, and start may be high again then.
// A release scans the address memory one entry per cycle through its read port:
// a match at entry k leads to S_LAST, which copies the last live entry into slot k,
// then registers the result; a miss is flagged once the last live entry is checked.
// Synchronous reset empties the table at once; the receiver cannot stall.
module outstanding_allocation_tracker
  import oat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = ADDR_BITS_DEF,
  parameter int SIZE_BITS     = SIZE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int SW = (SIZE_BITS < ASIZE_W) ? SIZE_BITS : ASIZE_W;
  localparam int IW = $clog2(TABLE_ENTRIES);

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_size;
  logic [IW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_size;

  oat_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW),
    .SW            (SW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_addr   (wr_addr),
    .wr_size   (wr_size),
    .rd_idx    (rd_idx),
    .rd_addr   (rd_addr),
    .rd_size   (rd_size)
  );

  oat_mem #(
    .WIDTH (AW),
    .DEPTH (TABLE_ENTRIES)
  ) u_addr_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_addr),
    .rd_idx  (rd_idx),
    .rd_data (rd_addr)
  );

  oat_mem #(
    .WIDTH (SW),
    .DEPTH (TABLE_ENTRIES)
  ) u_size_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_size),
    .rd_idx  (rd_idx),
    .rd_data (rd_size)
  );

endmodule

/* design/oat_chk.sv */
module oat_chk
  import oat_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // A null-address transaction is answered in the next cycle as ignored.
  a_null_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.address == '0) |=> (out_valid && out_data.status == ST_NULL))
    else $error("null address not answered in the next cycle");

  // Allocations never enter the scan and finish in the next cycle.
  a_alloc_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == KIND_ALLOC) |=> (out_valid && !busy))
    else $error("allocation did not complete in one cycle");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.usage_peak >= out_data.usage_now))
    else $error("peak usage below current usage");

  a_freed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DONE) |-> (out_data.freed_size == '0))
    else $error("freed size reported on a transaction that removed nothing");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

endmodule

bind outstanding_allocation_tracker oat_chk u_oat_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
